// ===== rtl/rau_pkg.sv =====
// Package for the rational arithmetic unit: constants, operation codes,
// sequencer states and status codes. No dependencies.
`default_nettype none
package rau_pkg;
  localparam int WORD_BITS_DEF = 32;

  typedef enum logic [2:0] {
    FN_ADD = 3'd0, FN_SUB = 3'd1, FN_MUL = 3'd2, FN_DIV = 3'd3,
    FN_NEG = 3'd4, FN_INC = 3'd5, FN_DEC = 3'd6, FN_EQ = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_ZERO = 2'd1, ST_OVF = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_COMB, S_GCD, S_DIVN, S_DIVD, S_FIN, S_OUT
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/rau_divider.sv =====
// Shared restoring divider: one quotient bit a cycle, used for the gcd
// remainders and the two reducing divisions.
`default_nettype none
module rau_divider #(
  parameter int W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quot,
  output logic [W-1:0]      rem
);
  localparam int CW = $clog2(W + 1);
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W-1:0]  dsr;
  logic [W:0]    trial;

  assign trial = {rem, quot[W-1]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(W);
      quot <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      if (trial[W]) begin
        rem  <= {rem[W-2:0], quot[W-1]};
        quot <= {quot[W-2:0], 1'b0};
      end else begin
        rem  <= trial[W-1:0];
        quot <= {quot[W-2:0], 1'b1};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rational_arithmetic_unit.sv =====
// Top level of the rational arithmetic unit: sequencer, one shared
// multiplier and the shared divider. Depends on rau_pkg and rau_divider.
//
// One request at a time. Operands are cross-multiplied on one shared
// WORD_BITS x WORD_BITS multiplier (three products, one a cycle), combined,
// then the gcd of numerator and denominator magnitudes is found by Euclid on
// the shared bit-serial divider, and both are divided by it. Each division
// is a launch, the shift steps and a pickup of the quotient and remainder.
// Euclid takes at least one step. A request with a zero denominator or a
// division by zero goes straight to the result; an equality request skips
// the gcd and the divisions.
// in_stall is high until the result is taken.
`default_nettype none
module rational_arithmetic_unit #(
  parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  func,
  input  wire logic signed [31:0] a_num,
  input  wire logic signed [31:0] a_den,
  input  wire logic signed [31:0] b_num,
  input  wire logic signed [31:0] b_den,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [31:0] res_num,
  output logic [30:0]      res_den,
  output logic             is_equal,
  output logic [1:0]       status
);
  import rau_pkg::*;
  localparam int W  = WORD_BITS;
  localparam int DW = 2 * WORD_BITS + 1;

  state_t state, state_next;
  func_t  fn;
  // magnitudes and signs of the operands
  logic [W:0]    an, ad, bn, bd;
  logic          ans, ads, bns, bds;
  logic [DW-1:0] p1, p2, p3;
  logic          s1, s2, s3;
  logic [DW-1:0] nm, dm, gx, gy;
  // first gcd cycle: load the Euclid pair
  logic          g_init;
  logic          nneg, dneg;
  logic [W:0]    mx, my;
  logic [DW-1:0] prod;

  logic          dv_start, dv_done;
  logic [DW-1:0] dv_a, dv_b, dv_q, dv_r;

  rau_divider #(.W(DW)) u_div (
    .clk(clk), .rst(rst), .start(dv_start), .dividend(dv_a), .divisor(dv_b),
    .done(dv_done), .quot(dv_q), .rem(dv_r)
  );

  // sign-extend the low WORD_BITS bits and return the magnitude
  function automatic logic [W:0] mag_of(input logic [31:0] v);
    logic [W:0] x;
    x = {v[W-1], v[W-1:0]};
    return x[W] ? (~x + 1'b1) : x;
  endfunction

  logic binary, bad;
  assign binary = (func <= 3'(FN_DIV)) || (func == 3'(FN_EQ));
  assign bad = (mag_of(a_den) == '0) || (binary && mag_of(b_den) == '0) ||
               (func == 3'(FN_DIV) && mag_of(b_num) == '0);

  // shared multiplier
  assign prod = DW'(mx) * DW'(my);

  // signed-magnitude add of p1 and p2
  logic [DW-1:0] sum_m;
  logic          sum_s;
  always_comb begin
    if (s1 == s2) begin
      sum_m = p1 + p2; sum_s = s1;
    end else if (p1 >= p2) begin
      sum_m = p1 - p2; sum_s = s1;
    end else begin
      sum_m = p2 - p1; sum_s = s2;
    end
  end

  // multiplier operand select per step
  always_comb begin
    mx = an; my = bd;
    unique case (state)
      S_MUL1: begin
        mx = an;
        my = (fn == FN_MUL) ? bn : bd;
      end
      S_MUL2: begin
        mx = (fn == FN_DIV) ? ad : bn;
        my = (fn == FN_DIV) ? bn : ad;
      end
      S_MUL3: begin
        mx = ad;
        my = (fn == FN_NEG || fn == FN_INC || fn == FN_DEC) ? (W+1)'(1) : bd;
      end
      default: begin
        mx = an; my = bd;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid && !in_stall) state_next = bad ? S_OUT : S_MUL1;
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = S_MUL3;
      S_MUL3: state_next = (fn == FN_EQ) ? S_OUT : S_COMB;
      S_COMB: state_next = S_GCD;
      S_GCD:  if (!g_init && gy == '0) state_next = S_DIVN;
      S_DIVN: if (dv_done) state_next = S_DIVD;
      S_DIVD: if (dv_done) state_next = S_FIN;
      S_FIN:  state_next = S_OUT;
      S_OUT:  if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // divider launch: one pulse at entry of each division
  logic dv_busy;
  always_comb begin
    dv_start = 1'b0;
    dv_a = gx; dv_b = gy;
    unique case (state)
      S_GCD:  dv_start = !dv_busy && (gy != '0);
      S_DIVN: begin dv_start = !dv_busy; dv_a = nm; dv_b = gx; end
      S_DIVD: begin dv_start = !dv_busy; dv_a = dm; dv_b = gx; end
      default: dv_start = 1'b0;
    endcase
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  logic          rneg, ovf;
  logic [DW-1:0] half, rval;
  assign half = DW'(1) << (W - 1);
  assign rneg = (nm != '0) && (nneg != dneg);
  assign ovf  = (rneg ? (nm > half) : (nm > half - 1'b1)) || (dm > half - 1'b1);
  assign rval = rneg ? (~nm + 1'b1) : nm;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      dv_busy <= 1'b0;
    end else begin
      state <= state_next;
      if (dv_start) dv_busy <= 1'b1;
      else if (dv_done) dv_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: if (in_valid && !in_stall) begin
        fn  <= func_t'(func);
        an  <= mag_of(a_num); ans <= a_num[W-1];
        ad  <= mag_of(a_den); ads <= a_den[W-1];
        bn  <= mag_of(b_num); bns <= b_num[W-1];
        bd  <= mag_of(b_den); bds <= b_den[W-1];
        res_num  <= '0;
        res_den  <= '0;
        is_equal <= 1'b0;
        status   <= bad ? 2'(ST_ZERO) : 2'(ST_OK);
      end
      S_MUL1: begin
        p1 <= prod;
        s1 <= (prod != '0) && (ans ^ ((fn == FN_MUL) ? bns : bds));
      end
      S_MUL2: begin
        p2 <= prod;
        // negate the second term for subtract; divide keeps it as denominator
        s2 <= (prod != '0) && ((bns ^ ads) ^ (fn == FN_SUB));
      end
      S_MUL3: begin
        p3 <= prod;
        s3 <= (prod != '0) && ((fn == FN_NEG || fn == FN_INC || fn == FN_DEC) ?
              ads : (ads ^ bds));
        // signs are already zero for zero products
        if (fn == FN_EQ) is_equal <= (p1 == p2) && (s1 == s2);
      end
      S_COMB: begin
        unique case (fn) inside
          FN_ADD, FN_SUB: begin nm <= sum_m; nneg <= sum_s; dm <= p3; dneg <= s3; end
          FN_MUL:         begin nm <= p1; nneg <= s1; dm <= p3; dneg <= s3; end
          FN_DIV:         begin nm <= p1; nneg <= s1; dm <= p2;
                                dneg <= (p2 != '0) && (ads ^ bns); end
          FN_NEG:         begin nm <= DW'(an); nneg <= (an != '0) && !ans;
                                dm <= DW'(ad); dneg <= ads; end
          default: begin
            // increment / decrement: an +/- ad in signed magnitude
            if (ans == (ads ^ (fn == FN_DEC))) begin
              nm <= DW'(an) + DW'(ad); nneg <= ans;
            end else if (an >= ad) begin
              nm <= DW'(an - ad); nneg <= (an != ad) && ans;
            end else begin
              nm <= DW'(ad - an); nneg <= ads ^ (fn == FN_DEC);
            end
            dm <= DW'(ad); dneg <= ads;
          end
        endcase
        gx <= '0; gy <= '0;
        g_init <= 1'b1;
      end
      S_GCD: begin
        if (g_init) begin
          gx <= nm; gy <= dm;
          g_init <= 1'b0;
        end else if (dv_done) begin
          gx <= gy; gy <= dv_r;
        end
      end
      S_DIVN: if (dv_done) nm <= dv_q;
      S_DIVD: if (dv_done) dm <= dv_q;
      S_FIN: begin
        res_num <= 32'(signed'(rval[W-1:0]));
        res_den <= 31'(dm[W-2:0]);
        status  <= ovf ? 2'(ST_OVF) : 2'(ST_OK);
      end
      default: ;
    endcase
  end

  // a request is never taken while a result is pending
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("accept while result pending");
  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(res_num) && $stable(status))
    else $error("result changed under stall");
  // equality requests report no fraction
  a_eq_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_equal |-> res_num == 0 && res_den == 0)
    else $error("equality carries fraction");
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for rational_arithmetic_unit: directed and random fraction requests,
// checked against a behavioral predictor. Depends on rau_pkg and the block RTL.
`default_nettype none
module tb;
  import rau_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] func = '0;
  logic signed [31:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] res_num;
  logic [30:0] res_den;
  logic is_equal;
  logic [1:0] status;

  typedef struct packed {
    logic signed [31:0] num;
    logic [30:0] den;
    logic eq;
    status_t st;
  } frac_result_t;

  frac_result_t pending_results[$];
  int errors = 0;
  // Idling control: random bursts unless quiet is set; hold_rx forces a long stall.
  bit quiet = 1'b0;
  bit hold_rx = 1'b0;
  int hold_rx_cycles = 0;

  rational_arithmetic_unit dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .func(func),
    .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .out_valid(out_valid), .out_stall(out_stall), .res_num(res_num),
    .res_den(res_den), .is_equal(is_equal), .status(status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Signed 66-bit magnitude helpers: operands are 32-bit, so all products fit
  // in 63 bits plus sign, and sums of two products fit in a 66-bit signed value.
  function automatic frac_result_t predict_fraction(logic [2:0] op, logic signed [31:0] an,
      logic signed [31:0] ad, logic signed [31:0] bn, logic signed [31:0] bd);
    logic signed [65:0] n, d, l, r;
    logic [65:0] nm, dm, x, y, t;
    logic neg, ovf;
    logic [65:0] val;
    frac_result_t res;
    bit binary;
    res = '0;
    res.st = ST_OK;
    binary = (op <= FN_DIV) || (op == FN_EQ);
    if (ad == 0 || (binary && bd == 0) || (op == FN_DIV && bn == 0)) begin
      res.st = ST_ZERO;
      return res;
    end
    if (op == FN_EQ) begin
      l = 66'(an) * 66'(bd);
      r = 66'(ad) * 66'(bn);
      res.eq = (l == r);
      return res;
    end
    case (op)
      FN_ADD: begin n = 66'(an) * 66'(bd) + 66'(bn) * 66'(ad); d = 66'(ad) * 66'(bd); end
      FN_SUB: begin n = 66'(an) * 66'(bd) - 66'(bn) * 66'(ad); d = 66'(ad) * 66'(bd); end
      FN_MUL: begin n = 66'(an) * 66'(bn); d = 66'(ad) * 66'(bd); end
      FN_DIV: begin n = 66'(an) * 66'(bd); d = 66'(ad) * 66'(bn); end
      FN_NEG: begin n = -66'(an); d = 66'(ad); end
      FN_INC: begin n = 66'(an) + 66'(ad); d = 66'(ad); end
      default: begin n = 66'(an) - 66'(ad); d = 66'(ad); end
    endcase
    nm = n < 0 ? -n : n;
    dm = d < 0 ? -d : d;
    x = nm;
    y = dm;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    if (x == 0) x = 1;
    nm = nm / x;
    dm = dm / x;
    neg = (nm != 0) && ((n < 0) != (d < 0));
    ovf = (neg ? (nm > 66'h8000_0000) : (nm > 66'h7FFF_FFFF)) || (dm > 66'h7FFF_FFFF);
    val = neg ? -nm : nm;
    res.num = val[31:0];
    res.den = dm[30:0];
    res.st = ovf ? ST_OVF : ST_OK;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // Receiver: random stall bursts, a long hold when asked, none when quiet.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        out_stall <= 1'b1;
        hold_rx_cycles++;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 19);
        out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Check each accepted result against the oldest prediction.
  initial begin
    frac_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", {res_num, 1'b0, res_den}, '0);
        end else begin
          want = pending_results.pop_front();
          if (res_num !== want.num)
            report_mismatch("res_num", 64'(res_num), 64'(want.num));
          if (res_den !== want.den)
            report_mismatch("res_den", 64'(res_den), 64'(want.den));
          if (is_equal !== want.eq)
            report_mismatch("is_equal", 64'(is_equal), 64'(want.eq));
          if (status !== want.st)
            report_mismatch("status", 64'(status), 64'(want.st));
        end
      end
    end
  end

  // Offer one request, predict it, and hold it until accepted. Valid stays
  // high after the accept; a random gap before the next request or a drain drops it.
  task automatic send_request(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
      logic [31:0] bn, logic [31:0] bd);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    func <= op;
    a_num <= an;
    a_den <= ad;
    b_num <= bn;
    b_den <= bd;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_fraction(op, an, ad, bn, bd));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      1: return 32'($signed($urandom_range(0, 20)) - 10);
      2: return 32'(int'($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    func_t op;
    op = op.first();
    do begin
      send_request(op, 3, 4, -5, 6);
      send_request(op, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      op = op.next();
    end while (op != op.first());
    send_request(FN_ADD, 1, 0, 1, 2);           // zero denominator in a
    send_request(FN_MUL, 1, 2, 1, 0);           // zero denominator in b
    send_request(FN_NEG, 1, 2, 1, 0);           // unary ignores b
    send_request(FN_DIV, 1, 2, 0, 5);           // divide by zero fraction
    send_request(FN_EQ, 2, 4, -1, -2);          // equal fractions
    send_request(FN_EQ, 1, 3, 1, 2);            // unequal
    send_request(FN_ADD, 0, -7, 0, 3);          // zero result reduces to 0/1
    send_request(FN_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(FN_NEG, 32'h8000_0000, 1, 0, 0); // overflow on negate
  endtask

  task automatic test_random(int count);
    repeat (count)
      send_request(3'($urandom_range(0, 7)), pick_operand(), pick_operand(),
                   pick_operand(), pick_operand());
  endtask

  // Hold the receiver off long enough for the block to stall its input.
  task automatic test_backpressure();
    hold_rx = 1'b1;
    hold_rx_cycles = 0;
    fork
      test_random(3);
      while (hold_rx_cycles < 2000) @(negedge clk);
    join_any
    while (hold_rx_cycles < 2000) @(negedge clk);
    hold_rx = 1'b0;
    wait fork;
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(900);
    test_backpressure();
    test_random(900);
    quiet = 1'b1;
    test_random(150);
    wait_drained();
    repeat (200) @(negedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // Worst case for about 2000 items plus stalls is near 140 million
  // time units; this stays several times above it.
  initial begin
    #1_000_000_000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/rau_pkg.sv
rtl/rau_divider.sv
rtl/rational_arithmetic_unit.sv
tb/tb.sv
